FILE: rtl/laplacian_variance_blur_score_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian blur score block
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_VARIANCE_BLUR_SCORE_MACROS_SVH
`define LAPLACIAN_VARIANCE_BLUR_SCORE_MACROS_SVH

// same-cycle implication
`define LVBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lvbs assertion failed");

// next-cycle implication
`define LVBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lvbs assertion failed");

`endif

FILE: rtl/lvbs_pkg.sv
// ----------------------------------------------------------------------------
// lvbs_pkg
// Shared types and codes for the Laplacian blur score block.
// ----------------------------------------------------------------------------
package lvbs_pkg;

  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int PIXEL_W = 8;
  localparam int MEAN_W  = 19;
  localparam int VAR_W   = 28;
  localparam int LAP_W   = 11;
  localparam int FRAC_W  = 8;

  localparam logic [IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_W-1:0] DIM_RESET      = 11'd1024;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_UPDATE,
    OP_ACCUM,
    OP_SETUP_MEAN,
    OP_DIV_STEP,
    OP_SETUP_PROD,
    OP_MUL_STEP,
    OP_SETUP_SQ,
    OP_SETUP_T,
    OP_SETUP_VAR,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic cfg_write;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic iter_last;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/lvbs_ram.sv
// ----------------------------------------------------------------------------
// lvbs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lvbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/lvbs_ctrl.sv
// ----------------------------------------------------------------------------
// lvbs_ctrl
// Sequencer: per-pixel steps and the end-of-frame divide/multiply program.
// ----------------------------------------------------------------------------
module lvbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pixel_valid_i,
  input  logic              cfg_valid_i,
  input  lvbs_pkg::status_t status_i,
  output lvbs_pkg::cmd_t    cmd_o,
  output logic              pixel_stall_o,
  output logic              cfg_ready_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UPD  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_SETN = 4'd3;
  localparam logic [3:0] S_DM   = 4'd4;
  localparam logic [3:0] S_SP   = 4'd5;
  localparam logic [3:0] S_MP   = 4'd6;
  localparam logic [3:0] S_SS   = 4'd7;
  localparam logic [3:0] S_MS   = 4'd8;
  localparam logic [3:0] S_ST   = 4'd9;
  localparam logic [3:0] S_DT   = 4'd10;
  localparam logic [3:0] S_SV   = 4'd11;
  localparam logic [3:0] S_DV   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_q, state_d;

  assign cfg_ready_o   = (state_q == S_IDLE);
  // config has priority in idle
  assign pixel_stall_o = (state_q != S_IDLE) || cfg_valid_i;

  always_comb begin
    state_d          = state_q;
    cmd_o.op         = lvbs_pkg::OP_NONE;
    cmd_o.cfg_write  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_write = 1'b1;
        end else if (pixel_valid_i) begin
          cmd_o.op = lvbs_pkg::OP_ACCEPT;
          state_d  = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.op = lvbs_pkg::OP_UPDATE;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = lvbs_pkg::OP_ACCUM;
        state_d  = status_i.frame_end ? S_SETN : S_IDLE;
      end
      S_SETN: begin
        cmd_o.op = lvbs_pkg::OP_SETUP_MEAN;
        state_d  = S_DM;
      end
      S_DM: begin
        cmd_o.op = lvbs_pkg::OP_DIV_STEP;
        if (status_i.iter_last) state_d = S_SP;
      end
      S_SP: begin
        cmd_o.op = lvbs_pkg::OP_SETUP_PROD;
        state_d  = S_MP;
      end
      S_MP: begin
        cmd_o.op = lvbs_pkg::OP_MUL_STEP;
        if (status_i.iter_last) state_d = S_SS;
      end
      S_SS: begin
        cmd_o.op = lvbs_pkg::OP_SETUP_SQ;
        state_d  = S_MS;
      end
      S_MS: begin
        cmd_o.op = lvbs_pkg::OP_MUL_STEP;
        if (status_i.iter_last) state_d = S_ST;
      end
      S_ST: begin
        cmd_o.op = lvbs_pkg::OP_SETUP_T;
        state_d  = S_DT;
      end
      S_DT: begin
        cmd_o.op = lvbs_pkg::OP_DIV_STEP;
        if (status_i.iter_last) state_d = S_SV;
      end
      S_SV: begin
        cmd_o.op = lvbs_pkg::OP_SETUP_VAR;
        state_d  = S_DV;
      end
      S_DV: begin
        cmd_o.op = lvbs_pkg::OP_DIV_STEP;
        if (status_i.iter_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.op = lvbs_pkg::OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/lvbs_dp.sv
// ----------------------------------------------------------------------------
// lvbs_dp
// Datapath: line store, window, sums, serial multiplier and divider.
// ----------------------------------------------------------------------------
module lvbs_dp #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int MAX_ROW_COUNT  = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lvbs_pkg::cmd_t                      cmd_i,
  output lvbs_pkg::status_t                   status_o,
  input  logic [lvbs_pkg::PIXEL_W-1:0]        pixel_i,
  input  logic [lvbs_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [lvbs_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                result_stall_i,
  output logic                                result_valid_o,
  output logic signed [lvbs_pkg::MEAN_W-1:0]  laplacian_mean_o,
  output logic [lvbs_pkg::VAR_W-1:0]          blur_variance_o
);

  localparam int CW   = $clog2(MAX_ROW_LENGTH);
  localparam int RW   = $clog2(MAX_ROW_COUNT);
  localparam int NW   = CW + RW;
  localparam int SW   = NW + lvbs_pkg::LAP_W;
  localparam int SQW  = NW + 20;
  localparam int PW   = SQW + NW;
  localparam int DW   = PW + lvbs_pkg::FRAC_W;
  localparam int CNTW = $clog2(DW + 1);
  localparam int PXW  = lvbs_pkg::PIXEL_W;

  // configuration and position
  logic [lvbs_pkg::CFG_W-1:0] row_length_q, row_count_q;
  logic [CW-1:0]              column_q;
  logic [RW-1:0]              row_q;
  logic [CW:0]                cols;
  logic [RW:0]                rows;
  logic                       col_last, row_last;

  always_comb begin
    if (32'(row_length_q) < 3) cols = (CW+1)'(3);
    else if (32'(row_length_q) > MAX_ROW_LENGTH) cols = (CW+1)'(MAX_ROW_LENGTH);
    else cols = (CW+1)'(row_length_q);
    if (32'(row_count_q) < 3) rows = (RW+1)'(3);
    else if (32'(row_count_q) > MAX_ROW_COUNT) rows = (RW+1)'(MAX_ROW_COUNT);
    else rows = (RW+1)'(row_count_q);
  end

  assign col_last = ({1'b0, column_q} == cols - (CW+1)'(1));
  assign row_last = ({1'b0, row_q} == rows - (RW+1)'(1));

  // line store: {older row, newer row} per column
  logic [2*PXW-1:0] ram_rdata;
  logic [PXW-1:0]   older, newer;
  logic             op_accept, op_update;

  assign op_accept = (cmd_i.op == lvbs_pkg::OP_ACCEPT);
  assign op_update = (cmd_i.op == lvbs_pkg::OP_UPDATE);
  assign older     = ram_rdata[2*PXW-1:PXW];
  assign newer     = ram_rdata[PXW-1:0];

  logic [PXW-1:0] pixel_q;

  lvbs_ram #(
    .WIDTH (2*PXW),
    .DEPTH (MAX_ROW_LENGTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (op_update),
    .waddr_i (column_q),
    .wdata_i ({newer, pixel_q}),
    .re_i    (op_accept),
    .raddr_i (column_q),
    .rdata_o (ram_rdata)
  );

  // window taps: previous column of each row, two back for the middle row
  logic [PXW-1:0] nw_m1_q, nw_m2_q, old_m1_q, px_m1_q;
  logic signed [lvbs_pkg::LAP_W-1:0] lap_d, lap_q;
  logic                              lap_vld_q;

  assign lap_d = $signed({3'b000, old_m1_q}) + $signed({3'b000, nw_m2_q})
               + $signed({3'b000, newer})    + $signed({3'b000, px_m1_q})
               - $signed({1'b0, nw_m1_q, 2'b00});

  // running sums
  logic signed [SW-1:0]           sum_q;
  logic [SQW-1:0]                 sq_q;
  logic signed [2*lvbs_pkg::LAP_W-1:0] lap_sq;
  logic [SW-1:0]                  smag;

  assign lap_sq = lap_q * lap_q;
  assign smag   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

  // shared serial units
  logic [NW-1:0]   n_q, rem_q, rem_d;
  logic [DW-1:0]   quo_q;
  logic [NW:0]     trial;
  logic            ge;
  logic [PW-1:0]   mul_a_q, acc_q, prod_q, diff;
  logic [SW-1:0]   mul_b_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   n_full;
  logic signed [lvbs_pkg::MEAN_W-1:0] mean_q;
  logic [lvbs_pkg::MEAN_W-1:0] mq;

  assign trial  = {rem_q, quo_q[DW-1]};
  assign ge     = (trial >= {1'b0, n_q});
  assign rem_d  = ge ? NW'(trial - {1'b0, n_q}) : trial[NW-1:0];
  assign n_full = NW'(cols - (CW+1)'(2)) * NW'(rows - (RW+1)'(2));
  assign diff   = (prod_q > acc_q) ? prod_q - acc_q : '0;
  assign mq     = quo_q[lvbs_pkg::MEAN_W-1:0];

  assign status_o.frame_end = col_last && row_last;
  assign status_o.iter_last = (cnt_q == CNTW'(1));
  assign status_o.out_busy  = result_valid_o && result_stall_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q   <= lvbs_pkg::DIM_RESET;
      row_count_q    <= lvbs_pkg::DIM_RESET;
      column_q       <= '0;
      row_q          <= '0;
      sum_q          <= '0;
      sq_q           <= '0;
      lap_vld_q      <= 1'b0;
      cnt_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      if (cmd_i.op == lvbs_pkg::OP_FINISH) result_valid_o <= 1'b1;
      else if (result_valid_o && !result_stall_i) result_valid_o <= 1'b0;
      if (cmd_i.cfg_write) begin
        case (cfg_index_i)
          lvbs_pkg::REG_ROW_LENGTH: begin
            row_length_q <= cfg_data_i;
            column_q <= '0; row_q <= '0; sum_q <= '0; sq_q <= '0;
          end
          lvbs_pkg::REG_ROW_COUNT: begin
            row_count_q <= cfg_data_i;
            column_q <= '0; row_q <= '0; sum_q <= '0; sq_q <= '0;
          end
          default: ;
        endcase
      end
      case (cmd_i.op)
        lvbs_pkg::OP_UPDATE: begin
          lap_vld_q <= (32'(row_q) >= 2) && (32'(column_q) >= 2);
        end
        lvbs_pkg::OP_ACCUM: begin
          if (lap_vld_q) begin
            sum_q <= sum_q + SW'(lap_q);
            sq_q  <= sq_q + SQW'($unsigned(lap_sq));
          end
          if (col_last) begin
            column_q <= '0;
            row_q    <= row_last ? '0 : row_q + RW'(1);
          end else begin
            column_q <= column_q + CW'(1);
          end
        end
        lvbs_pkg::OP_SETUP_MEAN, lvbs_pkg::OP_SETUP_T, lvbs_pkg::OP_SETUP_VAR: begin
          cnt_q <= CNTW'(DW);
        end
        lvbs_pkg::OP_SETUP_PROD, lvbs_pkg::OP_SETUP_SQ: begin
          cnt_q <= CNTW'(SW);
        end
        lvbs_pkg::OP_DIV_STEP, lvbs_pkg::OP_MUL_STEP: begin
          cnt_q <= cnt_q - CNTW'(1);
        end
        lvbs_pkg::OP_FINISH: begin
          sum_q <= '0;
          sq_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lvbs_pkg::OP_ACCEPT: begin
        pixel_q <= pixel_i;
      end
      lvbs_pkg::OP_UPDATE: begin
        lap_q    <= lap_d;
        nw_m2_q  <= nw_m1_q;
        nw_m1_q  <= newer;
        old_m1_q <= older;
        px_m1_q  <= pixel_q;
      end
      lvbs_pkg::OP_SETUP_MEAN: begin
        n_q   <= n_full;
        quo_q <= DW'(smag) << lvbs_pkg::FRAC_W;
        rem_q <= '0;
      end
      lvbs_pkg::OP_DIV_STEP: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DW-2:0], ge};
      end
      lvbs_pkg::OP_SETUP_PROD: begin
        mean_q  <= sum_q[SW-1] ? $signed(-mq) : $signed(mq);
        mul_a_q <= PW'(sq_q);
        mul_b_q <= SW'(n_q);
        acc_q   <= '0;
      end
      lvbs_pkg::OP_MUL_STEP: begin
        if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
        mul_a_q <= mul_a_q << 1;
        mul_b_q <= mul_b_q >> 1;
      end
      lvbs_pkg::OP_SETUP_SQ: begin
        prod_q  <= acc_q;
        mul_a_q <= PW'(smag);
        mul_b_q <= smag;
        acc_q   <= '0;
      end
      lvbs_pkg::OP_SETUP_T: begin
        quo_q <= {diff, {lvbs_pkg::FRAC_W{1'b0}}};
        rem_q <= '0;
      end
      lvbs_pkg::OP_SETUP_VAR: begin
        rem_q <= '0;
      end
      lvbs_pkg::OP_FINISH: begin
        laplacian_mean_o <= mean_q;
        blur_variance_o  <= quo_q[lvbs_pkg::VAR_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/laplacian_variance_blur_score.sv
// ----------------------------------------------------------------------------
// laplacian_variance_blur_score
// Variance-of-Laplacian focus metric over one grayscale frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each goes through a line-store read, a
// window update with Laplacian and an accumulate step before the next
// pixel is taken. After the last pixel of a frame one
// shared restoring divider (1 bit/clock) and one shift-add multiplier run the
// closing math, with divider width DW = 2*NW+28, multiplier width SW = NW+11,
// NW = clog2(MAX_ROW_LENGTH)+clog2(MAX_ROW_COUNT).
// The result (mean and variance, 8 fraction bits, truncated) then sits in an
// output register; pixels of the next frame are taken meanwhile, and only
// that frame's closing step waits until the previous result has been taken.
// A config write restarts the frame; out-of-range sizes are
// clamped to [3, MAX]. Line store contents are never cleared.
// ----------------------------------------------------------------------------
module laplacian_variance_blur_score #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int MAX_ROW_COUNT  = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel input
  input  logic                               pixel_valid_i,
  output logic                               pixel_stall_o,
  input  logic [lvbs_pkg::PIXEL_W-1:0]       pixel_i,
  // result output
  output logic                               result_valid_o,
  input  logic                               result_stall_i,
  output logic signed [lvbs_pkg::MEAN_W-1:0] laplacian_mean_o,
  output logic [lvbs_pkg::VAR_W-1:0]         blur_variance_o,
  // config writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lvbs_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [lvbs_pkg::CFG_W-1:0]         cfg_data_i
);

`include "laplacian_variance_blur_score_macros.svh"

  lvbs_pkg::cmd_t    cmd;
  lvbs_pkg::status_t status;
  logic              pixel_take;
  logic              mean_ok;

  lvbs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .cfg_valid_i   (cfg_valid_i),
    .status_i      (status),
    .cmd_o         (cmd),
    .pixel_stall_o (pixel_stall_o),
    .cfg_ready_o   (cfg_ready_o)
  );

  lvbs_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_ROW_COUNT  (MAX_ROW_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .pixel_i          (pixel_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_stall_i   (result_stall_i),
    .result_valid_o   (result_valid_o),
    .laplacian_mean_o (laplacian_mean_o),
    .blur_variance_o  (blur_variance_o)
  );

  assign pixel_take = pixel_valid_i && !pixel_stall_o;
  assign mean_ok    = (laplacian_mean_o <= 19'sd261120) && (laplacian_mean_o >= -19'sd261120);

  // an accepted pixel keeps the block busy for its update step
  `LVBS_ASSERT_NEXT(a_busy_after_pixel, clk_i, rst_ni, pixel_take, pixel_stall_o && !cfg_ready_o)
  // never a config write and a pixel in the same cycle
  `LVBS_ASSERT_IMPL(a_cfg_excl, clk_i, rst_ni, cfg_valid_i && cfg_ready_o, pixel_stall_o)
  // the mean stays within the Laplacian range
  `LVBS_ASSERT_IMPL(a_mean_range, clk_i, rst_ni, result_valid_o, mean_ok)
  // a new result only appears after the finish step, never mid-frame
  `LVBS_ASSERT_IMPL(a_result_rise, clk_i, rst_ni, $rose(result_valid_o), cfg_ready_o)

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Laplacian blur score testbench
// Streams grayscale frames of many sizes through the block and checks the
// per-frame mean and variance of the Laplacian against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;

  // index with no register behind it, writes must be ignored
  localparam logic [lvbs_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int MAX_DIM = 1024;
  // leave margin for the closing math before touching config
  localparam int SETTLE_CYCLES = 400;

  typedef enum int {PAT_FLAT0, PAT_SPIKE, PAT_PIT, PAT_NOISE, PAT_CHECKER,
                    PAT_RAMP, PAT_DOTS, PAT_FLAT} pattern_e;
  typedef enum int {ROW_CFG, ROW_FRAME} row_kind_e;

  typedef struct {
    logic signed [lvbs_pkg::MEAN_W-1:0] mean;
    logic [lvbs_pkg::VAR_W-1:0]         variance;
  } score_t;

  typedef struct {
    row_kind_e                  kind;
    logic [lvbs_pkg::IDX_W-1:0] index;
    logic [lvbs_pkg::CFG_W-1:0] value;
    pattern_e                   pattern;
    bit                         known;
    score_t                     score;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic pixel_valid_i = 1'b0;
  logic pixel_stall_o;
  logic [lvbs_pkg::PIXEL_W-1:0] pixel_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic signed [lvbs_pkg::MEAN_W-1:0] laplacian_mean_o;
  logic [lvbs_pkg::VAR_W-1:0] blur_variance_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lvbs_pkg::IDX_W-1:0] cfg_index_i = '0;
  logic [lvbs_pkg::CFG_W-1:0] cfg_data_i = '0;

  laplacian_variance_blur_score dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame model: raw register values, line buffers, window, running sums
  // ---------------------------------------------------------------------------
  logic [lvbs_pkg::CFG_W-1:0] width_reg = lvbs_pkg::DIM_RESET;
  logic [lvbs_pkg::CFG_W-1:0] height_reg = lvbs_pkg::DIM_RESET;
  int  line_buf[2][MAX_DIM];
  int  win[3][3];
  int  col_pos, row_pos;
  longint lap_sum;
  longint unsigned lap_sq_sum;

  score_t scores_due[$];
  int     errors = 0;
  bit     tx_calm = 1'b0;   // no sender gaps while set
  bit     rx_calm = 1'b0;   // no receiver stalls while set

  function automatic int fit_dim(logic [lvbs_pkg::CFG_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    lap_sum = 0;
    lap_sq_sum = 0;
    foreach (win[r, c]) win[r][c] = 0;
  endfunction

  // advance the model by one pixel; returns 1 when the frame closes
  function automatic bit score_pixel(int px, output score_t sc);
    int cols, rows, cc, older, newer, lap;
    longint unsigned n, smag, mq, prod, sq, d, q, rem, t;
    cols = fit_dim(width_reg);
    rows = fit_dim(height_reg);
    cc = (col_pos >= cols) ? cols - 1 : col_pos;
    older = line_buf[1][cc];
    newer = line_buf[0][cc];
    line_buf[1][cc] = newer;
    line_buf[0][cc] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = older;
    win[1][2] = newer;
    win[2][2] = px;
    if (row_pos >= 2 && cc >= 2) begin
      lap = win[0][1] + win[1][0] + win[1][2] + win[2][1] - 4 * win[1][1];
      lap_sum += lap;
      lap_sq_sum += longint'(lap) * longint'(lap);
    end
    if (cc + 1 < cols) begin
      col_pos = cc + 1;
      return 1'b0;
    end
    col_pos = 0;
    if (row_pos + 1 < rows) begin
      row_pos++;
      return 1'b0;
    end
    // exact integer form of sumsq/N - (sum/N)^2, 8 fraction bits
    n = longint'(rows - 2) * longint'(cols - 2);
    smag = (lap_sum < 0) ? -lap_sum : lap_sum;
    mq = (smag * 256) / n;
    sc.mean = (lap_sum < 0) ? lvbs_pkg::MEAN_W'(-mq) : lvbs_pkg::MEAN_W'(mq);
    prod = lap_sq_sum * n;
    sq = smag * smag;
    d = (prod > sq) ? prod - sq : 0;
    q = d / n;
    rem = d % n;
    t = q * 256 + (rem * 256) / n;
    sc.variance = lvbs_pkg::VAR_W'(t / n);
    restart_frame();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  int pixels_sent = 0;

  task automatic send_pixel(input int px, input bit known, input score_t known_score);
    score_t sc;
    while (!tx_calm && $urandom_range(99) < 21) begin
      pixel_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i <= lvbs_pkg::PIXEL_W'(px);
    do @(posedge clk_i); while (pixel_stall_o);
    pixels_sent++;
    if (score_pixel(px, sc)) scores_due.push_back(known ? known_score : sc);
  endtask

  // let every pending result drain and the closing math finish
  task automatic settle();
    pixel_valid_i <= 1'b0;
    while (scores_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lvbs_pkg::IDX_W-1:0] idx,
                           input logic [lvbs_pkg::CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == lvbs_pkg::REG_ROW_LENGTH) begin
      width_reg = val;
      restart_frame();
    end else if (idx == lvbs_pkg::REG_ROW_COUNT) begin
      height_reg = val;
      restart_frame();
    end
    @(posedge clk_i);
  endtask

  function automatic int pattern_pixel(pattern_e pat, int r, int c, int level);
    case (pat)
      PAT_FLAT0:   return 0;
      PAT_SPIKE:   return (r == 1 && c == 1) ? 255 : 0;
      PAT_PIT:     return (r == 1 && c == 1) ? 0 : 255;
      PAT_CHECKER: return ((r + c) % 2 != 0) ? 255 : 0;
      PAT_RAMP:    return (r * 7 + c * level) % 256;
      PAT_DOTS:    return ($urandom_range(9) == 0) ? 255 : level % 16;
      PAT_FLAT:    return level;
      default:     return $urandom_range(255);
    endcase
  endfunction

  // count < 0 sends the whole frame; otherwise stops early
  task automatic send_frame(input pattern_e pat, input bit known, input score_t sc,
                            input int count);
    int cols, rows, level, sent;
    cols = fit_dim(width_reg);
    rows = fit_dim(height_reg);
    level = $urandom_range(255);
    sent = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (count >= 0 && sent == count) return;
        send_pixel(pattern_pixel(pat, r, c, level), known, sc);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, compare against the oldest expected score
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_stall_i <= !rx_calm && ($urandom_range(99) < 21);
  end

  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (scores_due.size() == 0) begin
        $display("%0t: unexpected result mean=%0d variance=%0d", $time,
                 laplacian_mean_o, blur_variance_o);
        errors++;
      end else begin
        want = scores_due.pop_front();
        if (laplacian_mean_o !== want.mean) begin
          $display("%0t: laplacian_mean expected %0d got %0d", $time,
                   want.mean, laplacian_mean_o);
          errors++;
        end
        if (blur_variance_o !== want.variance) begin
          $display("%0t: blur_variance expected %0d got %0d", $time,
                   want.variance, blur_variance_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t directed[$];

  function automatic stim_row_t cfg_row(logic [lvbs_pkg::IDX_W-1:0] idx,
                                        logic [lvbs_pkg::CFG_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.index = idx;
    row.value = val;
    row.pattern = PAT_FLAT0;
    row.known = 1'b0;
    row.score = '{0, 0};
    return row;
  endfunction

  function automatic stim_row_t frame_row(pattern_e pat, bit known, int mean, int variance);
    stim_row_t row;
    row = cfg_row(lvbs_pkg::REG_ROW_LENGTH, '0);
    row.kind = ROW_FRAME;
    row.pattern = pat;
    row.known = known;
    row.score.mean = lvbs_pkg::MEAN_W'(mean);
    row.score.variance = lvbs_pkg::VAR_W'(variance);
    return row;
  endfunction

  initial begin
    int cols_pick, rows_pick, frames;
    restart_frame();
    foreach (line_buf[i, j]) line_buf[i][j] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: sizes below 3 clamp up, unused index ignored, then 3x3
    // frames where the single interior pixel makes the answer obvious.
    directed.push_back(cfg_row(lvbs_pkg::REG_ROW_LENGTH, 11'd0));
    directed.push_back(cfg_row(lvbs_pkg::REG_ROW_COUNT, 11'd2));
    directed.push_back(cfg_row(REG_UNUSED, 11'd5));
    directed.push_back(frame_row(PAT_FLAT0, 1'b1, 0, 0));
    directed.push_back(frame_row(PAT_SPIKE, 1'b1, -261120, 0));   // most negative
    directed.push_back(frame_row(PAT_PIT, 1'b1, 261120, 0));      // most positive
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_reg(directed[i].index, directed[i].value);
      else send_frame(directed[i].pattern, directed[i].known, directed[i].score, -1);
    end
    settle();

    // Random: phases of one setting each; a few phases use long thin
    // frames or sizes that clamp up to 3, most stay small.
    for (int phase = 0; pixels_sent < 2000; phase++) begin
      case (phase % 12)
        3:  begin cols_pick = $urandom_range(30, 100); rows_pick = 3; end
        7:  begin cols_pick = 3; rows_pick = $urandom_range(30, 100); end
        10: begin cols_pick = $urandom_range(2); rows_pick = $urandom_range(4); end
        default: begin
          cols_pick = $urandom_range(3, 16);
          rows_pick = $urandom_range(3, 10);
        end
      endcase
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, lvbs_pkg::CFG_W'($urandom));
      write_reg(lvbs_pkg::REG_ROW_LENGTH, lvbs_pkg::CFG_W'(cols_pick));
      write_reg(lvbs_pkg::REG_ROW_COUNT, lvbs_pkg::CFG_W'(rows_pick));
      tx_calm = (phase % 9 == 4);
      rx_calm = tx_calm;
      frames = (phase % 12 == 3 || phase % 12 == 7) ? 1 : $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
        send_frame(pattern_e'($urandom_range(PAT_NOISE, PAT_FLAT)), 1'b0, '{0, 0}, -1);
        // now and then the sender holds off until all scores are back
        if ($urandom_range(5) == 0) settle();
      end
      // sometimes abandon a frame part way; the next write restarts it
      if ($urandom_range(4) == 0)
        send_frame(PAT_NOISE, 1'b0, '{0, 0},
                   $urandom_range(1, fit_dim(width_reg) * 3));
      settle();
    end

    tx_calm = 1'b0;
    rx_calm = 1'b0;
    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lvbs_pkg.sv
rtl/lvbs_ram.sv
rtl/lvbs_ctrl.sv
rtl/lvbs_dp.sv
rtl/laplacian_variance_blur_score.sv
verif/testbench.sv
